// ----- src/lrc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrc_pkg: shared constants and types for the local relief colormap block
// Holds raster geometry, register indexes, reset values and the divider
// request type.
// ----------------------------------------------------------------------------
package lrc_pkg;

  localparam int RasterWidth  = 260;
  localparam int RasterHeight = 260;
  localparam int WindowRadius = 2;
  localparam int WinSide      = 2 * WindowRadius + 1;
  localparam int HistRows     = 2 * WindowRadius;
  localparam int WinCount     = WinSide * WinSide;

  localparam int ColW  = $clog2(RasterWidth);
  localparam int RowW  = $clog2(RasterHeight);
  localparam int CntW  = $clog2(WinCount + 1);
  localparam int SumW  = 24 + CntW;
  // D = center*count - sum, and key*count products.
  localparam int DW    = 24 + CntW + 2;
  // numerator * (h - l): DW + 9 bits
  localparam int NumW  = DW + 9;
  localparam int QW    = 10;

  typedef enum logic [2:0] {
    REG_NODATA  = 3'd0,
    REG_HOLE    = 3'd1,
    REG_PEAK    = 3'd2,
    REG_HCOL    = 3'd3,
    REG_NCOL    = 3'd4,
    REG_PCOL    = 3'd5
  } reg_idx_t;

  localparam logic signed [23:0] NodataReset = -24'sd255744;
  localparam logic signed [23:0] HoleReset   = -24'sd2560;
  localparam logic [22:0]        PeakReset   = 23'd3072;
  localparam logic [31:0]        HColReset   = 32'd1077952511;
  localparam logic [31:0]        NColReset   = 32'd255;
  localparam logic [31:0]        PColReset   = 32'hFFFFFFFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SHIFT,
    ST_SUM,
    ST_PROD,
    ST_DIV,
    ST_OUT
  } state_t;

  // Request to the shared channel divider: floor(num / den), num >= 0.
  typedef struct packed {
    logic                   start;
    logic [NumW-1:0]        num;
    logic [DW-1:0]          den;
  } div_req_t;

endpackage

// ----- src/lrc_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrc_div: restoring divider
// Computes floor(num / den) for a non-negative numerator, one quotient bit
// per cycle. Only the low QW quotient bits are kept; callers clamp.
// ----------------------------------------------------------------------------
module lrc_div (
  input  logic                clk,
  input  logic                rst,
  input  lrc_pkg::div_req_t   req,
  output logic                done,
  output logic [lrc_pkg::QW-1:0] quot,
  output logic                over
);
  import lrc_pkg::*;

  localparam int StepW = $clog2(NumW + 1);

  logic [NumW-1:0]  rem;
  logic [NumW-1:0]  num;
  logic [DW-1:0]    den;
  logic [QW-1:0]    q;
  logic             big;
  logic [StepW-1:0] step;
  logic             busy;
  logic [NumW:0]    trial;

  // Shift the next numerator bit into the partial remainder and compare.
  assign trial = {rem, num[NumW-1]} - {{(NumW+1-DW){1'b0}}, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= StepW'(NumW);
      end else if (busy) begin
        step <= step - 1'b1;
        if (step == StepW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      num <= req.num;
      den <= req.den;
      q   <= '0;
      big <= 1'b0;
    end else if (busy) begin
      num <= {num[NumW-2:0], 1'b0};
      big <= big | q[QW-1];
      if (!trial[NumW]) begin
        rem <= trial[NumW-1:0];
        q   <= {q[QW-2:0], 1'b1};
      end else begin
        rem <= {rem[NumW-2:0], num[NumW-1]};
        q   <= {q[QW-2:0], 1'b0};
      end
    end
  end

  assign quot = q;
  assign over = big;

endmodule

// ----- src/local_relief_colormap_5x5_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// local_relief_colormap_5x5_unit: local relief shading over a 5x5 window
// Streams elevation samples through line memories and shades each full window.
// ----------------------------------------------------------------------------
// One sample is taken at a time. Each sample reads one word of the line memory
// (a registered read, four history rows side by side) and shifts the window.
// For a pixel whose center is valid, the unit then sums the valid samples of
// the 25-sample window, one per cycle, registers the products in ST_PROD and
// runs the four channel blends in turn; channels in the low and high regions
// go through a shared bit-serial divider. A finished pixel waits in an output
// register, so the next sample proceeds while it is unclaimed; the input stalls
// only when a second pixel is ready first. The line memory needs no clearing
// pass.
module local_relief_colormap_5x5_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic signed [23:0] elevation,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [7:0]  alpha,
  output logic        frame_end,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import lrc_pkg::*;

  localparam int WinW = $clog2(WinCount);

  // Blend regions of the relief difference.
  localparam logic [1:0] RgnHole = 2'd0;
  localparam logic [1:0] RgnLow  = 2'd1;
  localparam logic [1:0] RgnPeak = 2'd2;
  localparam logic [1:0] RgnHigh = 2'd3;

  // Configuration registers.
  logic signed [23:0] nodata, hole_key;
  logic [22:0]        peak_key;
  logic [31:0]        hcol, ncol, pcol;

  always_ff @(posedge clk) begin
    if (rst) begin
      nodata   <= NodataReset;
      hole_key <= HoleReset;
      peak_key <= PeakReset;
      hcol     <= HColReset;
      ncol     <= NColReset;
      pcol     <= PColReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NODATA: nodata   <= cfg_data[23:0];
        REG_HOLE:   hole_key <= cfg_data[23:0];
        REG_PEAK:   peak_key <= cfg_data[22:0];
        REG_HCOL:   hcol     <= cfg_data;
        REG_NCOL:   ncol     <= cfg_data;
        REG_PCOL:   pcol     <= cfg_data;
        default: ;
      endcase
    end
  end

  state_t state, state_next;
  logic [ColW-1:0] col;
  logic [RowW-1:0] row;
  logic signed [23:0] sample;
  logic            emit, last;

  // Line memory: one word per column holds all history rows, oldest at bit 0.
  logic [HistRows*24-1:0] line_mem [RasterWidth];
  logic [HistRows*24-1:0] line_rd;
  logic [23:0] win [WinSide][WinSide];

  logic take;
  assign in_ready = (state == ST_IDLE);
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (take) sample <= elevation;
  end

  // Read in ST_READ, write back the shifted column in ST_SHIFT.
  always_ff @(posedge clk) begin
    if (state == ST_READ)  line_rd <= line_mem[col];
    if (state == ST_SHIFT) line_mem[col] <= {sample, line_rd[HistRows*24-1:24]};
  end

  always_ff @(posedge clk) begin
    if (state == ST_SHIFT) begin
      for (int r = 0; r < WinSide; r++) begin
        for (int c = 0; c < WinSide - 1; c++) win[r][c] <= win[r][c+1];
      end
      for (int r = 0; r < HistRows; r++) win[r][WinSide-1] <= line_rd[24*r +: 24];
      win[HistRows][WinSide-1] <= sample;
    end
  end

  // Serial accumulation over the window.
  logic [WinW-1:0]         sidx;
  logic signed [SumW-1:0]  sum;
  logic [CntW-1:0]         cnt;
  logic signed [23:0]      cur;
  logic signed [23:0]      center;

  always_comb begin
    cur = '0;
    for (int k = 0; k < WinCount; k++)
      if (sidx == WinW'(k)) cur = win[k / WinSide][k % WinSide];
  end
  assign center = win[WindowRadius][WindowRadius];

  // Blend setup, one channel at a time.
  logic [1:0]              ch;
  logic                    sum_done;
  logic                    nd_center;
  logic                    nd_center_pre;
  logic signed [DW-1:0]    dval, hk_cnt, pk_cnt;
  logic [1:0]              region;
  logic [7:0]              pix [4];
  logic                    div_done, div_over;
  logic [QW-1:0]           div_q;
  div_req_t                dreq;
  logic                    div_wait;
  logic                    load_out;

  assign sum_done = (sidx == WinW'(WinCount - 1));

  always_ff @(posedge clk) begin
    if (state == ST_SHIFT) begin
      sidx <= '0;
      sum  <= '0;
      cnt  <= '0;
    end else if (state == ST_SUM) begin
      sidx <= sidx + 1'b1;
      if (cur != nodata) begin
        sum <= sum + SumW'(cur);
        cnt <= cnt + 1'b1;
      end
    end
  end

  // Products after the sum are registered before use.
  logic sum_fin;
  always_ff @(posedge clk) begin
    if (rst) sum_fin <= 1'b0;
    else     sum_fin <= (state == ST_SUM) && sum_done;
  end

  always_ff @(posedge clk) begin
    if (sum_fin) begin
      dval   <= DW'(center) * DW'(signed'({1'b0, cnt})) - DW'(sum);
      hk_cnt <= DW'(hole_key) * DW'(signed'({1'b0, cnt}));
      pk_cnt <= DW'(signed'({1'b0, peak_key})) * DW'(signed'({1'b0, cnt}));
    end
  end

  logic [7:0] lo_c, hi_c;
  logic signed [9:0] span;
  logic signed [DW-1:0] bnum, bden;
  always_comb begin
    if (dval <= hk_cnt)        region = RgnHole;
    else if (dval <= 0)        region = RgnLow;
    else if (dval > pk_cnt)    region = RgnPeak;
    else                       region = RgnHigh;
    lo_c = (region == RgnLow) ? hcol[31 - 8*ch -: 8] : ncol[31 - 8*ch -: 8];
    hi_c = (region == RgnLow) ? ncol[31 - 8*ch -: 8] : pcol[31 - 8*ch -: 8];
    span = 10'(signed'({2'b0, hi_c})) - 10'(signed'({2'b0, lo_c}));
    bnum = (region == RgnLow) ? dval - hk_cnt : dval;
    bden = (region == RgnLow) ? -hk_cnt : pk_cnt;
  end

  // Divide |num*span| by den; negative spans use a ceiling so floor holds.
  logic [NumW-1:0] prod_mag;
  logic            neg;
  logic [NumW-1:0] prod;
  assign neg      = span[9];
  assign prod_mag = NumW'(bnum) * NumW'(neg ? -span : span);
  assign prod     = neg ? prod_mag + NumW'(bden) - 1'b1 : prod_mag;

  always_comb begin
    dreq.start = (state == ST_DIV) && !div_wait && (region == RgnLow || region == RgnHigh);
    dreq.num   = prod;
    dreq.den   = bden;
  end

  lrc_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (dreq),
    .done (div_done),
    .quot (div_q),
    .over (div_over)
  );

  logic [9:0] qsat;
  logic signed [10:0] chval;
  assign qsat  = (div_over || div_q > 10'd255) ? 10'd255 : div_q;
  assign chval = neg ? 11'(lo_c) - 11'(qsat) : 11'(lo_c) + 11'(qsat);

  logic step_done;
  always_ff @(posedge clk) begin
    if (rst) begin
      div_wait <= 1'b0;
      ch       <= '0;
    end else begin
      if (state == ST_SHIFT) ch <= '0;
      if (dreq.start) div_wait <= 1'b1;
      if (div_done)   div_wait <= 1'b0;
      if (step_done)  ch <= ch + 1'b1;
    end
  end

  assign step_done = (state == ST_DIV) &&
                     (div_done || (!div_wait && (region == RgnHole || region == RgnPeak)));

  always_ff @(posedge clk) begin
    if (step_done) begin
      if (region == RgnHole)      pix[ch] <= hcol[31 - 8*ch -: 8];
      else if (region == RgnPeak) pix[ch] <= pcol[31 - 8*ch -: 8];
      else if (chval < 0)         pix[ch] <= 8'd0;
      else if (chval > 255)       pix[ch] <= 8'd255;
      else                        pix[ch] <= chval[7:0];
    end
  end

  // The center after the shift is the column to its right before it.
  assign nd_center_pre = (win[WindowRadius][WindowRadius+1] == nodata);

  always_ff @(posedge clk) begin
    if (state == ST_SHIFT) nd_center <= nd_center_pre;
  end

  // Raster counters advance when the sample is stored.
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (state == ST_SHIFT) begin
      if (col == ColW'(RasterWidth - 1)) begin
        col <= '0;
        row <= (row == RowW'(RasterHeight - 1)) ? '0 : row + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      emit <= (row >= RowW'(HistRows)) && (col >= ColW'(HistRows));
      last <= (row == RowW'(RasterHeight - 1)) && (col == ColW'(RasterWidth - 1));
    end
  end

  // A finished pixel moves to the output register once that register is free.
  assign load_out = (state == ST_OUT) && (!out_valid || out_ready);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (take) state_next = ST_READ;
      ST_READ:  state_next = ST_SHIFT;
      ST_SHIFT: state_next = emit ? (nd_center_pre ? ST_OUT : ST_SUM) : ST_IDLE;
      ST_SUM:   if (sum_done) state_next = ST_PROD;
      ST_PROD:  state_next = ST_DIV;
      ST_DIV:   if (step_done && ch == 2'd3) state_next = ST_OUT;
      ST_OUT:   if (load_out) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // ST_PROD loads the product registers before ST_DIV uses them.
  logic div_arm;
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end
  assign div_arm = sum_fin;

  // Output register: holds a pixel until its transfer.
  always_ff @(posedge clk) begin
    if (rst)            out_valid <= 1'b0;
    else if (load_out)  out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      red       <= nd_center ? 8'd0 : pix[0];
      green     <= nd_center ? 8'd0 : pix[1];
      blue      <= nd_center ? 8'd0 : pix[2];
      alpha     <= nd_center ? 8'd0 : pix[3];
      frame_end <= last;
    end
  end

  // A divider start is never issued while the product registers are loading.
  assert property (@(posedge clk) disable iff (rst) div_arm |-> !dreq.start)
    else $error("divider started before products were ready");
  assert property (@(posedge clk) disable iff (rst)
                   out_valid && !out_ready |=>
                   out_valid && $stable({red, green, blue, alpha, frame_end}))
    else $error("pending pixel changed before its transfer");
  assert property (@(posedge clk) disable iff (rst) div_done |-> $past(div_wait))
    else $error("divider finished without a request");

endmodule
